@@ hw/rtl/kaau_pkg.sv @@
// Package with the shared types, constants and helpers of the k-means step engine.
`timescale 1ns / 1ps
package kaau_pkg;

  localparam int MAX_MEANS = 8;
  localparam int MAX_DIMS  = 8;
  localparam int MI_W      = $clog2(MAX_MEANS);
  localparam int DI_W      = $clog2(MAX_DIMS);
  localparam int ENT_W     = MI_W + DI_W;
  localparam int DIST_W    = 36;
  localparam int CNT_W     = 16;
  localparam int DIV_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MEANS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE  = 2'd1;

  typedef enum logic [2:0] {
    OP_LOAD_MEAN  = 3'd0,
    OP_LOAD_FLOOR = 3'd1,
    OP_SCORE      = 3'd2,
    OP_SCORE_ACC  = 3'd3,
    OP_UPDATE     = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_MUL,
    S_SC_ACC,
    S_MIN,
    S_EMIT_C,
    S_AC_RD,
    S_AC_WR,
    S_UP_W,
    S_UP_WW,
    S_UP_RD,
    S_UP_CHK,
    S_UP_SW,
    S_UP_QGO,
    S_UP_QW,
    S_UP_MM,
    S_UP_VAR,
    S_UP_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         mean_index;
    logic [2:0]         dim_index;
    logic signed [15:0] value;
    logic               last_element;
  } in_t;

  typedef struct packed {
    logic                  result_kind;
    logic [2:0]            best_index;
    logic [DIST_W-1:0]     best_distance;
    logic [2:0]            entry_dim;
    logic signed [15:0]    new_mean;
    logic [31:0]           new_variance;
    logic [15:0]           new_weight;
    logic                  empty_mean;
    logic                  last_result;
  } out_t;

  typedef struct packed {
    logic signed [31:0] sum;
    logic [47:0]        sq;
  } acc_t;

  // Active count from a register: zero counts as one, large values saturate.
  function automatic logic [3:0] clamp_active(input logic [3:0] v, input logic [3:0] maxv);
    logic [3:0] r;
    begin
      if (v == 4'd0) r = 4'd1;
      else if (v > maxv) r = maxv;
      else r = v;
      return r;
    end
  endfunction

endpackage

@@ hw/rtl/kaau_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module kaau_ram #(
  parameter int W  = 16,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/kaau_div.sv @@
// Iterative restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module kaau_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kaau_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]                divisor,
  output logic                       busy,
  output logic [kaau_pkg::DIV_W-1:0] quotient
);
  import kaau_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r;
  logic [15:0]      rem_r;
  logic [15:0]      dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [16:0]      rem_sh;
  logic             fit;

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign fit    = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIV_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fit};
      rem_r <= fit ? 16'(rem_sh - {1'b0, dvs_r}) : rem_sh[15:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
endmodule

@@ hw/rtl/kmeans_assign_accumulate_update.sv @@
// Top level of the k-means step engine: sequencer, state registers and memories.
`timescale 1ns / 1ps
// Usage: items enter on the in_ channel (in_valid, in_stall, in_data) and results leave
// on the out_ channel (out_valid, out_stall, out_data); a transfer happens at a clock
// edge where valid is high and stall is low. The cfg_ channel writes means_in_use
// (index 0) and dims_in_use (index 1) and is always ready; write it only while idle.
// One item is worked on at a time; in_stall stays high until its work is done.
// Load items are done in the idle state. A score element reads each active mean from
// the mean memory through one shared subtract-square-accumulate unit, with a read,
// a multiply and an accumulate state per mean. The last element adds a nearest-mean
// search over the active means and a state that hands the result to the output
// register; an accumulating score whose winner's count has not saturated then reads
// and writes the accumulator memory for each dimension. An update runs a weight
// division for each mean and two 48-step divisions for each entry, both skipped for
// a mean with no samples. Reset clears the counters, distances, floors and valid bits
// of both memories at once, so there is no clearing pass. When the receiver stalls,
// the finished result waits in the output register while the sequencer goes on until
// it needs that register again.
module kmeans_assign_accumulate_update (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  kaau_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output kaau_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kaau_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kaau_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import kaau_pkg::*;

  state_t state_r, state_nxt;

  logic [3:0] means_cfg_r, dims_cfg_r;
  logic [3:0] nm, nd;
  logic [2:0] nm_m1, nd_m1;

  logic [2:0]         op_r, di_r, j_r, k_r, best_r;
  logic signed [15:0] x_r;
  logic               lastel_r;
  logic [DIST_W-1:0]  bd_r;
  logic [33:0]        sq_r;
  logic [15:0]        w_r;
  logic signed [15:0] m_r;
  logic [47:0]        sqs_r, ex_r;
  logic [31:0]        mm_r, var_r;
  logic               neg_r;

  logic [DIST_W-1:0]  pd_r   [MAX_MEANS];
  logic [CNT_W-1:0]   cnt_r  [MAX_MEANS];
  logic [CNT_W-1:0]   total_r;
  logic [31:0]        floor_r [MAX_DIMS];
  logic signed [15:0] sbuf_r [MAX_DIMS];
  logic [2**ENT_W-1:0] mean_vld_r, acc_vld_r;
  logic               mvld_q_r, avld_q_r;

  out_t out_r, out_nxt;
  logic out_valid_r;
  logic out_free;

  // Memory ports.
  logic               mean_we;
  logic [ENT_W-1:0]   mean_waddr, mean_raddr;
  logic [15:0]        mean_wdata, mean_rdata;
  logic               acc_we;
  logic [ENT_W-1:0]   acc_addr;
  acc_t               acc_wdata, acc_rdata;

  // Divider.
  logic               div_start, div_busy;
  logic [DIV_W-1:0]   div_dividend, div_quot;
  logic [15:0]        div_divisor;

  logic in_acc;
  logic signed [15:0] m_mem;
  logic signed [16:0] diff;
  logic [36:0]        dsum;
  logic signed [15:0] zk;
  logic [15:0]        q_lo;
  logic signed [48:0] var_diff;

  assign nm    = clamp_active(means_cfg_r, 4'(MAX_MEANS));
  assign nd    = clamp_active(dims_cfg_r, 4'(MAX_DIMS));
  assign nm_m1 = 3'(nm - 4'd1);
  assign nd_m1 = 3'(nd - 4'd1);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign m_mem    = mvld_q_r ? $signed(mean_rdata) : 16'sd0;
  assign diff     = 17'(x_r) - 17'(m_mem);
  assign dsum     = {1'b0, pd_r[j_r]} + {3'b0, sq_r};
  assign zk       = sbuf_r[k_r];
  assign q_lo     = div_quot[15:0];
  assign var_diff = $signed({1'b0, ex_r}) - $signed({17'b0, mm_r});

  kaau_ram #(.W(16), .AW(ENT_W)) u_mean_ram (
    .clk(clk), .we(mean_we), .waddr(mean_waddr), .wdata(mean_wdata),
    .raddr(mean_raddr), .rdata(mean_rdata)
  );

  kaau_ram #(.W($bits(acc_t)), .AW(ENT_W)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_addr), .wdata(acc_wdata),
    .raddr(acc_addr), .rdata(acc_rdata)
  );

  kaau_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .quotient(div_quot)
  );

  // Next state and memory/divider controls.
  always_comb begin
    state_nxt    = state_r;
    mean_we      = 1'b0;
    mean_waddr   = {j_r, k_r};
    mean_wdata   = m_r;
    mean_raddr   = {j_r, k_r};
    acc_we       = 1'b0;
    acc_addr     = {best_r, k_r};
    acc_wdata    = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = cnt_r[j_r];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.operation)
            OP_LOAD_MEAN: begin
              mean_we    = 1'b1;
              mean_waddr = {in_data.mean_index, in_data.dim_index};
              mean_wdata = in_data.value;
            end
            OP_SCORE, OP_SCORE_ACC: begin
              if ({1'b0, in_data.dim_index} < nd) state_nxt = S_SC_RD;
              else if (in_data.last_element) state_nxt = S_MIN;
            end
            OP_UPDATE: state_nxt = S_UP_W;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SC_RD: begin
        mean_raddr = {j_r, di_r};
        state_nxt  = S_SC_MUL;
      end
      S_SC_MUL: state_nxt = S_SC_ACC;
      S_SC_ACC: begin
        if (j_r != nm_m1) state_nxt = S_SC_RD;
        else if (lastel_r) state_nxt = S_MIN;
        else state_nxt = S_IDLE;
      end
      S_MIN: begin
        if (j_r == nm_m1) state_nxt = S_EMIT_C;
      end
      S_EMIT_C: begin
        if (out_free) begin
          if (op_r == OP_SCORE_ACC && cnt_r[best_r] != '1) state_nxt = S_AC_RD;
          else state_nxt = S_IDLE;
        end
      end
      S_AC_RD: state_nxt = S_AC_WR;
      S_AC_WR: begin
        acc_we        = 1'b1;
        acc_wdata.sum = (avld_q_r ? acc_rdata.sum : 32'sd0) + 32'(zk);
        acc_wdata.sq  = (avld_q_r ? acc_rdata.sq : 48'd0) + 48'(sq_r);
        state_nxt     = (k_r == nd_m1) ? S_IDLE : S_AC_RD;
      end
      S_UP_W: begin
        div_dividend = DIV_W'({cnt_r[j_r], 16'b0});
        div_divisor  = total_r;
        if (cnt_r[j_r] != '0 && total_r != '0) begin
          div_start = 1'b1;
          state_nxt = S_UP_WW;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_UP_WW: if (!div_busy) state_nxt = S_UP_RD;
      S_UP_RD: begin
        acc_addr  = {j_r, k_r};
        state_nxt = S_UP_CHK;
      end
      S_UP_CHK: begin
        // An entry not accumulated since the last update holds a zero sum.
        if (avld_q_r)
          div_dividend = DIV_W'(acc_rdata.sum[31] ? 33'(-$signed({acc_rdata.sum[31],
                                                                  acc_rdata.sum}))
                                                  : {1'b0, acc_rdata.sum});
        if (cnt_r[j_r] == '0) begin
          state_nxt = S_UP_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_UP_SW;
        end
      end
      S_UP_SW: if (!div_busy) state_nxt = S_UP_QGO;
      S_UP_QGO: begin
        div_dividend = sqs_r;
        div_start    = 1'b1;
        state_nxt    = S_UP_QW;
      end
      S_UP_QW: if (!div_busy) state_nxt = S_UP_MM;
      S_UP_MM: state_nxt = S_UP_VAR;
      S_UP_VAR: begin
        mean_we   = 1'b1;
        state_nxt = S_UP_EMIT;
      end
      S_UP_EMIT: begin
        if (out_free) begin
          if (k_r != nd_m1) state_nxt = S_UP_RD;
          else if (j_r != nm_m1) state_nxt = S_UP_W;
          else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      means_cfg_r <= 4'(MAX_MEANS);
      dims_cfg_r  <= 4'(MAX_DIMS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEANS_IN_USE: means_cfg_r <= cfg_data;
        REG_DIMS_IN_USE:  dims_cfg_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits read alongside the memories.
  always_ff @(posedge clk) begin
    mvld_q_r <= mean_vld_r[mean_raddr];
    avld_q_r <= acc_vld_r[acc_addr];
  end

  // Sample buffer holds no reset value; an accumulating score still reads unwritten elements.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && (in_data.operation == OP_SCORE ||
        in_data.operation == OP_SCORE_ACC) && {1'b0, in_data.dim_index} < nd)
      sbuf_r[in_data.dim_index] <= in_data.value;
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r     <= in_data.operation;
          di_r     <= in_data.dim_index;
          x_r      <= in_data.value;
          lastel_r <= in_data.last_element;
          j_r      <= '0;
          k_r      <= '0;
        end
      end
      S_SC_MUL: sq_r <= 34'(diff * diff);
      S_SC_ACC: begin
        if (j_r != nm_m1) j_r <= j_r + 1'b1;
        else j_r <= '0;
      end
      S_MIN: begin
        if (j_r == '0 || pd_r[j_r] < bd_r) begin
          bd_r   <= pd_r[j_r];
          best_r <= j_r;
        end
        j_r <= j_r + 1'b1;
      end
      S_EMIT_C: k_r <= '0;
      S_AC_RD: sq_r <= 34'(zk * zk);
      S_AC_WR: k_r <= k_r + 1'b1;
      S_UP_W: begin
        k_r <= '0;
        w_r <= '0;
      end
      S_UP_WW: begin
        if (!div_busy) w_r <= (div_quot > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
      end
      S_UP_CHK: begin
        m_r   <= m_mem;
        var_r <= floor_r[k_r];
        sqs_r <= avld_q_r ? acc_rdata.sq : 48'd0;
        neg_r <= avld_q_r && acc_rdata.sum[31];
      end
      S_UP_SW: begin
        if (!div_busy) begin
          if (!neg_r) m_r <= (div_quot > DIV_W'(32767)) ? 16'sh7FFF : $signed(q_lo);
          else m_r <= (div_quot > DIV_W'(32768)) ? 16'sh8000 : $signed(16'(-q_lo));
        end
      end
      S_UP_QW: if (!div_busy) ex_r <= div_quot;
      S_UP_MM: mm_r <= 32'(m_r * m_r);
      S_UP_VAR: begin
        if (var_diff > $signed({17'b0, var_r})) var_r <= var_diff[31:0];
      end
      S_UP_EMIT: begin
        if (out_free) begin
          if (k_r != nd_m1) k_r <= k_r + 1'b1;
          else j_r <= j_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state: distances, counts, floors, valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_MEANS; i++) begin
        pd_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
      for (int i = 0; i < MAX_DIMS; i++) floor_r[i] <= '0;
      total_r    <= '0;
      mean_vld_r <= '0;
      acc_vld_r  <= '0;
    end else begin
      if (state_r == S_IDLE && in_acc) begin
        if (in_data.operation == OP_LOAD_MEAN)
          mean_vld_r[{in_data.mean_index, in_data.dim_index}] <= 1'b1;
        if (in_data.operation == OP_LOAD_FLOOR)
          floor_r[in_data.dim_index] <= in_data.value[15] ? 32'd0
                                      : {8'b0, in_data.value, 8'b0};
      end
      if (state_r == S_SC_ACC)
        pd_r[j_r] <= dsum[36] ? '1 : dsum[DIST_W-1:0];
      if (state_r == S_EMIT_C && out_free) begin
        for (int i = 0; i < MAX_MEANS; i++) pd_r[i] <= '0;
        if (op_r == OP_SCORE_ACC && cnt_r[best_r] != '1) begin
          cnt_r[best_r] <= cnt_r[best_r] + 1'b1;
          if (total_r != '1) total_r <= total_r + 1'b1;
        end
      end
      if (state_r == S_AC_WR) acc_vld_r[{best_r, k_r}] <= 1'b1;
      if (state_r == S_UP_VAR) mean_vld_r[{j_r, k_r}] <= 1'b1;
      if (state_r == S_UP_EMIT && out_free && k_r == nd_m1 && j_r == nm_m1) begin
        for (int i = 0; i < MAX_MEANS; i++) begin
          pd_r[i]  <= '0;
          cnt_r[i] <= '0;
        end
        total_r   <= '0;
        acc_vld_r <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT_C || state_r == S_UP_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // A classification carries only the winner and its distance; a model entry carries
  // everything but the distance.
  always_comb begin
    out_nxt = '0;
    if (state_r == S_UP_EMIT) begin
      out_nxt.result_kind  = 1'b1;
      out_nxt.best_index   = j_r;
      out_nxt.entry_dim    = k_r;
      out_nxt.new_mean     = m_r;
      out_nxt.new_variance = var_r;
      out_nxt.new_weight   = w_r;
      out_nxt.empty_mean   = (cnt_r[j_r] == '0);
      out_nxt.last_result  = (k_r == nd_m1) && (j_r == nm_m1);
    end else begin
      out_nxt.best_index    = best_r;
      out_nxt.best_distance = bd_r;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT_C || state_r == S_UP_EMIT) && out_free) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A final model entry is never a classification.
  a_last_is_model: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last_result |-> out_r.result_kind)
    else $error("last_result set on a classification");

  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_UP_WW || state_r == S_UP_SW || state_r == S_UP_QW))
    else $error("divider busy outside a wait state");

  // A result waiting on a stalled receiver stays in place.
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

  // No new item is taken in the emit state of an update or in the nearest-mean search.
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP_EMIT || state_r == S_MIN) |-> in_stall)
    else $error("input accepted while busy");
endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the k-means step engine with a scoreboard and predictor.
`timescale 1ns / 1ps
module tb;
  import kaau_pkg::*;

  localparam longint unsigned DIST_SAT = 64'hF_FFFF_FFFF;
  localparam int COUNT_SAT = 65535;

  // The scoreboard keeps its own copy of the model tables and accumulators. Every
  // accepted item updates that copy and queues the results the engine must produce.
  class kmeans_scoreboard;
    logic [3:0] means_reg, dims_reg;
    logic signed [15:0] mean_tab[64];
    logic [31:0] floor_tab[8];
    logic signed [15:0] sample_buf[8];
    longint unsigned dist_run[8];
    int samples_in[8];
    int samples_total;
    longint sum_tab[64];
    longint unsigned sq_tab[64];
    out_t pending[$];
    int mismatches, results_seen;

    function new();
      means_reg = 4'd8;
      dims_reg = 4'd8;
      for (int e = 0; e < 64; e++) begin
        mean_tab[e] = '0;
        sum_tab[e] = 0;
        sq_tab[e] = 0;
      end
      for (int k = 0; k < 8; k++) begin
        floor_tab[k] = '0;
        sample_buf[k] = '0;
        dist_run[k] = 0;
        samples_in[k] = 0;
      end
      samples_total = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int active(logic [3:0] v);
      if (v == 4'd0) return 1;
      return (v > 4'd8) ? 8 : int'(v);
    endfunction

    function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == REG_MEANS_IN_USE) means_reg = val;
      else if (idx == REG_DIMS_IN_USE) dims_reg = val;
    endfunction

    // Work out what one accepted transfer does to the model and what it emits.
    function void note_item(in_t it);
      int nm, nd, best, n, ent;
      longint x, d, q, ex, m, v;
      longint unsigned s, bd, w;
      out_t r;
      nm = active(means_reg);
      nd = active(dims_reg);
      x = longint'(it.value);
      if (it.operation == OP_LOAD_MEAN) begin
        mean_tab[it.mean_index * 8 + it.dim_index] = it.value;
      end else if (it.operation == OP_LOAD_FLOOR) begin
        // Negative floors load as zero; the Q8.8 value moves to Q16.16.
        floor_tab[it.dim_index] = (x < 0) ? 32'd0 : (32'(it.value) << 8);
      end else if (it.operation == OP_SCORE || it.operation == OP_SCORE_ACC) begin
        if (int'(it.dim_index) < nd) begin
          sample_buf[it.dim_index] = it.value;
          for (int j = 0; j < nm; j++) begin
            d = x - longint'(mean_tab[j * 8 + it.dim_index]);
            s = dist_run[j] + longint'(d * d);
            dist_run[j] = (s > DIST_SAT) ? DIST_SAT : s;
          end
        end
        if (it.last_element) begin
          best = 0;
          bd = dist_run[0];
          for (int j = 1; j < nm; j++)
            if (dist_run[j] < bd) begin
              bd = dist_run[j];
              best = j;
            end
          r = '0;
          r.best_index = best[2:0];
          r.best_distance = bd[DIST_W-1:0];
          pending.push_back(r);
          if (it.operation == OP_SCORE_ACC && samples_in[best] < COUNT_SAT) begin
            samples_in[best]++;
            if (samples_total < COUNT_SAT) samples_total++;
            for (int k = 0; k < nd; k++) begin
              sum_tab[best * 8 + k] += longint'(sample_buf[k]);
              sq_tab[best * 8 + k] += longint'(sample_buf[k]) * longint'(sample_buf[k]);
            end
          end
          for (int j = 0; j < 8; j++) dist_run[j] = 0;
        end
      end else if (it.operation == OP_UPDATE) begin
        for (int j = 0; j < nm; j++) begin
          n = samples_in[j];
          w = 0;
          if (n != 0 && samples_total != 0) begin
            w = (longint'(n) << 16) / samples_total;
            if (w > 65535) w = 65535;
          end
          for (int k = 0; k < nd; k++) begin
            ent = j * 8 + k;
            m = longint'(mean_tab[ent]);
            v = longint'(floor_tab[k]);
            if (n != 0) begin
              q = sum_tab[ent] / n;
              if (q > 32767) q = 32767;
              if (q < -32768) q = -32768;
              m = q;
              ex = longint'(sq_tab[ent] / n);
              if (ex - m * m > v) v = ex - m * m;
              mean_tab[ent] = m[15:0];
            end
            r = '0;
            r.result_kind = 1'b1;
            r.best_index = j[2:0];
            r.entry_dim = k[2:0];
            r.new_mean = m[15:0];
            r.new_variance = v[31:0];
            r.new_weight = w[15:0];
            r.empty_mean = (n == 0);
            r.last_result = (j == nm - 1 && k == nd - 1);
            pending.push_back(r);
          end
        end
        for (int j = 0; j < 8; j++) begin
          samples_in[j] = 0;
          dist_run[j] = 0;
        end
        samples_total = 0;
        for (int e = 0; e < 64; e++) begin
          sum_tab[e] = 0;
          sq_tab[e] = 0;
        end
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      bit ok;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      ok = (got.result_kind == want.result_kind) && (got.best_index == want.best_index) &&
           (got.best_distance == want.best_distance) && (got.entry_dim == want.entry_dim) &&
           (got.new_mean == want.new_mean) && (got.new_variance == want.new_variance) &&
           (got.new_weight == want.new_weight) && (got.empty_mean == want.empty_mean) &&
           (got.last_result == want.last_result);
      if (!ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: kind %0d/%0d idx %0d/%0d dist %h/%h dim %0d/%0d mean %h/%h var %h/%h w %h/%h empty %0d/%0d last %0d/%0d (exp/got)",
                   want.result_kind, got.result_kind, want.best_index, got.best_index,
                   want.best_distance, got.best_distance, want.entry_dim, got.entry_dim,
                   want.new_mean, got.new_mean, want.new_variance, got.new_variance,
                   want.new_weight, got.new_weight, want.empty_mean, got.empty_mean,
                   want.last_result, got.last_result);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_t in_data;
  out_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  kmeans_scoreboard sb;
  int send_idle_pct, stall_pct;
  int items_sent, vectors_sent, updates_sent;

  kmeans_assign_accumulate_update uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Result side: check every transfer on the out channel, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Present one item, idling first as the phase asks, and hold it until the transfer.
  // The valid is only lowered at the start of the next call, so it never gets two
  // assignments in one time step.
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    if (it.operation <= OP_UPDATE) items_sent++;
    if (it.operation == OP_UPDATE) updates_sent++;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t make_item(logic [2:0] op, logic [2:0] mi, logic [2:0] di,
                                    logic signed [15:0] val, logic lst);
    in_t it;
    it.operation = op;
    it.mean_index = mi;
    it.dim_index = di;
    it.value = val;
    it.last_element = lst;
    return it;
  endfunction

  // One sample vector. Now and then a dimension repeats or falls outside the active
  // range, and some vectors break off without a last mark.
  task automatic send_vector(logic [2:0] op);
    int nd;
    logic [2:0] di;
    bit broken;
    nd = sb.active(sb.dims_reg);
    broken = ($urandom_range(99) < 8);
    for (int k = 0; k < nd; k++) begin
      di = k[2:0];
      if ($urandom_range(99) < 10) di = 3'($urandom_range(7));
      send_item(make_item(op, 3'($urandom), di, pick_value(),
                          (k == nd - 1) && !broken));
    end
    vectors_sent++;
  endtask

  // Drop the valid at once so the last item is not taken twice, wait until nothing
  // is owed, then give a score element still in work time to end.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // The caller lowers cfg_valid after its last write.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_register(idx, val);
  endtask

  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int target, pick;
    logic [3:0] means_set[5], dims_set[5];
    means_set = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd5};
    dims_set = '{4'd8, 4'd2, 4'd15, 4'd4, 4'd0};
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    vectors_sent = 0;
    updates_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset sizes: extreme means, a negative and a large floor,
    // unused operation codes, a full score vector that fills the sample buffer, an
    // accumulating vector, then a full update in which most means are empty.
    send_item(make_item(OP_LOAD_MEAN, 3'd0, 3'd0, 16'sh8000, 1'b0));
    send_item(make_item(OP_LOAD_MEAN, 3'd7, 3'd7, 16'sh7FFF, 1'b1));
    send_item(make_item(OP_LOAD_FLOOR, 3'd0, 3'd0, -16'sd1, 1'b0));
    send_item(make_item(OP_LOAD_FLOOR, 3'd0, 3'd1, 16'sh7FFF, 1'b0));
    send_item(make_item(3'd5, 3'd7, 3'd7, 16'sh7FFF, 1'b1));
    send_item(make_item(3'd6, 3'd0, 3'd0, 16'sh0000, 1'b1));
    send_item(make_item(3'd7, 3'd0, 3'd0, 16'sh8000, 1'b1));
    for (int k = 0; k < 8; k++)
      send_item(make_item(OP_SCORE, 3'd0, k[2:0], (k == 0) ? 16'sh7FFF : pick_value(),
                          k == 7));
    for (int k = 0; k < 8; k++)
      send_item(make_item(OP_SCORE_ACC, 3'd0, k[2:0], pick_value(), k == 7));
    send_item(make_item(OP_UPDATE, 3'd0, 3'd0, 16'sh0000, 1'b0));

    // Distances large enough to saturate for every mean, so all tie at the top.
    for (int k = 0; k < 72; k++)
      send_item(make_item(OP_SCORE_ACC, 3'd0, 3'd0, k[0] ? 16'sh8000 : 16'sh7FFF,
                          k == 71));
    drain();

    // Random phases, each with its own sizes and idling pattern.
    for (int ph = 0; ph < 5; ph++) begin
      write_register(REG_MEANS_IN_USE, means_set[ph]);
      write_register(REG_DIMS_IN_USE, dims_set[ph]);
      cfg_valid <= 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      target = items_sent + 40;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 50) send_vector(OP_SCORE_ACC);
        else if (pick < 70) send_vector(OP_SCORE);
        else if (pick < 84)
          send_item(make_item(OP_LOAD_MEAN, 3'($urandom), 3'($urandom), pick_value(),
                              1'($urandom)));
        else if (pick < 92)
          send_item(make_item(OP_LOAD_FLOOR, 3'($urandom), 3'($urandom), pick_value(),
                              1'($urandom)));
        else if (pick < 95)
          send_item(make_item(3'($urandom_range(7, 5)), 3'($urandom), 3'($urandom),
                              pick_value(), 1'($urandom)));
        else
          send_item(make_item(OP_UPDATE, 3'($urandom), 3'($urandom), pick_value(),
                              1'($urandom)));
      end
      // Close the phase with an update so the accumulators are read out.
      send_item(make_item(OP_UPDATE, 3'd0, 3'd0, 16'sh0000, 1'b0));
      drain();
    end

    $display("Covered %0d items in %0d sample vectors and %0d updates over five sizes,",
             items_sent, vectors_sent, updates_sent);
    $display("checking %0d results with %0d mismatches.", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
